// ----- src/wmsum_pkg.sv -----
// Shared constants and types for the two-dimensional window minimum block.
// No dependencies; window_min_sum_2d, wmsum_row_min and wmsum_col_hist import it.
package wmsum_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_COLS_DEF   = 1024;
	localparam int MAX_WIN_H_DEF  = 16;
	localparam int MAX_WIN_W_DEF  = 16;
	localparam int PIXEL_BITS_DEF = 32;

	// Fixed frame limits and field widths
	localparam int MAX_ROWS     = 1024;
	localparam int ROW_W        = 10;
	localparam int FRAME_W      = 11;
	localparam int WINDOW_REG_W = 5;
	localparam int PIX_PORT_W   = 32;
	localparam int SUM_W        = 64;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_ROWS = 2'd0,
		REG_FRAME_COLS = 2'd1,
		REG_WIN_H      = 2'd2,
		REG_WIN_W      = 2'd3
	} cfg_reg_t;

	// Column history control from the top level
	typedef struct packed {
		logic adv;  // pipeline moves this cycle
		logic wr;   // item in stage 1 writes its row minimum
	} wmsum_hist_ctl_t;

endpackage

// ----- src/window_min_sum_2d.sv -----
// Two-dimensional sliding window minimum with a running sum over a raster stream.
// Pixels enter on the pixel channel (pixel_valid / pixel_stall), one per item in
// raster order. Every pixel that completes a win_h by win_w window gives one
// result item on the result channel (result_valid / result_stall): the window
// minimum, the saturating sum of minima so far in the frame, and frame_done on
// the last pixel of the frame. Pixels that complete no window give no result.
// Throughput: one pixel per cycle unless result_stall holds a waiting result.
// The accepting edge loads the row window; the column-history memory read, the
// minimum register and the sum/output register then follow in that order.
// The four stages move together; while result_stall holds a waiting result,
// pixel_stall rises and all stages hold; bubbles pass through. Configuration is
// written through cfg_we / cfg_index / cfg_data while idle; the user ensures it.
// Reset (arst_n low) clears the frame position, the sum and all valid flags and
// loads frame_rows = frame_cols = 1024, win_h = win_w = 1. The column history
// memory is not cleared; an entry feeding a result is written first in a frame.
// Depends on wmsum_pkg, wmsum_row_min, wmsum_col_hist.
module window_min_sum_2d #(
	parameter int MAX_COLS   = wmsum_pkg::MAX_COLS_DEF,
	parameter int MAX_WIN_H  = wmsum_pkg::MAX_WIN_H_DEF,
	parameter int MAX_WIN_W  = wmsum_pkg::MAX_WIN_W_DEF,
	parameter int PIXEL_BITS = wmsum_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wmsum_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wmsum_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [wmsum_pkg::PIX_PORT_W-1:0]  pixel,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [wmsum_pkg::PIX_PORT_W-1:0]  window_min,
	output logic [wmsum_pkg::SUM_W-1:0]       running_sum,
	output logic                              frame_done
);
	import wmsum_pkg::*;

	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SLOT_W  = (MAX_WIN_H > 1) ? $clog2(MAX_WIN_H) : 1;
	localparam int COLS_W  = $clog2(MAX_COLS + 1);
	localparam int CW      = (COLS_W > FRAME_W) ? COLS_W : FRAME_W;

	// Configuration registers
	logic [FRAME_W-1:0]      frame_rows_q, frame_cols_q;
	logic [WINDOW_REG_W-1:0] win_h_q, win_w_q;

	// Clamped configuration
	logic [FRAME_W-1:0]      rows_c;
	logic [CW-1:0]           cols_c;
	logic [WINDOW_REG_W-1:0] wh_c, ww_c;

	// Frame position
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic              row_end, frame_end, emit;

	// Pipeline
	logic                  adv, accept;
	logic                  valid_s1, emit_s1, fend_s1;
	logic [COL_W-1:0]      col_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic                  valid_s2, emit_s2, fend_s2;
	logic                  valid_s3, emit_s3, fend_s3;
	logic [PIXEL_BITS-1:0] vmin_s3;
	logic [PIXEL_BITS-1:0] hmin, vmin;
	wmsum_hist_ctl_t       hist_ctl;

	// Sum and result
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W:0]        sum_wide;
	logic [SUM_W-1:0]      sum_next;
	logic                  result_valid_q;
	logic [PIX_PORT_W-1:0] window_min_q;
	logic [SUM_W-1:0]      running_sum_q;
	logic                  frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= FRAME_W'(MAX_ROWS);
			frame_cols_q <= FRAME_W'(1024);
			win_h_q      <= WINDOW_REG_W'(1);
			win_w_q      <= WINDOW_REG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				REG_FRAME_COLS: frame_cols_q <= cfg_data;
				REG_WIN_H:      win_h_q      <= cfg_data[WINDOW_REG_W-1:0];
				REG_WIN_W:      win_w_q      <= cfg_data[WINDOW_REG_W-1:0];
				default:        ;
			endcase
		end
	end

	// Zero acts as one; large values saturate at the supported maximum
	always_comb begin
		if (frame_rows_q == '0) begin
			rows_c = FRAME_W'(1);
		end else if (int'(frame_rows_q) > MAX_ROWS) begin
			rows_c = FRAME_W'(MAX_ROWS);
		end else begin
			rows_c = frame_rows_q;
		end
		if (frame_cols_q == '0) begin
			cols_c = CW'(1);
		end else if (int'(frame_cols_q) > MAX_COLS) begin
			cols_c = CW'(MAX_COLS);
		end else begin
			cols_c = CW'(frame_cols_q);
		end
		if (win_h_q == '0) begin
			wh_c = WINDOW_REG_W'(1);
		end else if (int'(win_h_q) > MAX_WIN_H) begin
			wh_c = WINDOW_REG_W'(MAX_WIN_H);
		end else begin
			wh_c = win_h_q;
		end
		if (win_w_q == '0) begin
			ww_c = WINDOW_REG_W'(1);
		end else if (int'(win_w_q) > MAX_WIN_W) begin
			ww_c = WINDOW_REG_W'(MAX_WIN_W);
		end else begin
			ww_c = win_w_q;
		end
	end

	assign adv         = !result_valid_q || !result_stall;
	assign accept      = pixel_valid && adv;
	assign pixel_stall = !adv;

	assign row_end   = (CW'(col_q) + CW'(1)) >= cols_c;
	assign frame_end = row_end && ((FRAME_W'(row_q) + FRAME_W'(1)) >= rows_c);
	assign emit      = ((FRAME_W'(row_q) + FRAME_W'(1)) >= FRAME_W'(wh_c))
		&& ((CW'(col_q) + CW'(1)) >= CW'(ww_c));

	// Advance the frame position on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end else if (row_end) begin
				col_q  <= '0;
				row_q  <= row_q + ROW_W'(1);
				slot_q <= (slot_q == SLOT_W'(MAX_WIN_H - 1)) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1: row window minimum
	wmsum_row_min #(
		.MAX_WIN_W  (MAX_WIN_W),
		.PIXEL_BITS (PIXEL_BITS)
	) u_row (
		.clk   (clk),
		.load  (accept),
		.pixel (pixel[PIXEL_BITS-1:0]),
		.win_w (ww_c),
		.hmin  (hmin)
	);

	// Stage 2: column history write, read and column minimum
	assign hist_ctl.adv = adv;
	assign hist_ctl.wr  = valid_s1;

	wmsum_col_hist #(
		.MAX_COLS   (MAX_COLS),
		.MAX_WIN_H  (MAX_WIN_H),
		.PIXEL_BITS (PIXEL_BITS),
		.COL_W      (COL_W),
		.SLOT_W     (SLOT_W)
	) u_hist (
		.clk   (clk),
		.ctl   (hist_ctl),
		.col   (col_s1),
		.slot  (slot_s1),
		.hmin  (hmin),
		.win_h (wh_c),
		.vmin  (vmin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s1 <= emit;
			fend_s1 <= frame_end;
			col_s1  <= col_q;
			slot_s1 <= slot_q;
			emit_s2 <= emit_s1;
			fend_s2 <= fend_s1;
			emit_s3 <= emit_s2;
			fend_s3 <= fend_s2;
			vmin_s3 <= vmin;
		end
	end

	// Stage 4: saturating sum and result register
	assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(vmin_s3);
	assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s3 && emit_s3;
			if (valid_s3) begin
				if (fend_s3) begin
					sum_q <= '0;
				end else if (emit_s3) begin
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3 && emit_s3) begin
			window_min_q  <= PIX_PORT_W'(vmin_s3);
			running_sum_q <= sum_next;
			frame_done_q  <= fend_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign window_min   = window_min_q;
	assign running_sum  = running_sum_q;
	assign frame_done   = frame_done_q;

`ifndef SYNTHESIS
	// An empty result register never holds back the pixel channel
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !pixel_stall)
		else $error("pixel_stall high with empty result register");

	// The sum restarts after the last item of a frame leaves stage 3
	a_sum_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s3 && fend_s3) |=> (sum_q == '0))
		else $error("sum not cleared at end of frame");

	// The running sum always includes the minimum it is shown with
	a_sum_covers_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (running_sum >= SUM_W'(window_min)))
		else $error("running_sum below window_min");

	// The row slot stays within the history banks
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < MAX_WIN_H)
		else $error("row slot out of range");
`endif

endmodule

// ----- src/wmsum_min_tree.sv -----
// Balanced compare tree: minimum over the enabled lanes of a packed vector.
// Depends on nothing; used by the row window and the column history.
module wmsum_min_tree #(
	parameter int N = 16,
	parameter int W = 32
) (
	input  logic [N-1:0][W-1:0] din,
	input  logic [N-1:0]        en,
	output logic [W-1:0]        dmin
);
	localparam int LV = (N > 1) ? $clog2(N) : 0;
	localparam int P  = 1 << LV;

	logic [W-1:0] node [2*P-1];

	// Disabled and padding lanes read as all ones so they never win
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_real
			assign node[P-1+i] = en[i] ? din[i] : {W{1'b1}};
		end else begin : g_pad
			assign node[P-1+i] = {W{1'b1}};
		end
	end

	for (genvar i = 0; i < P - 1; i++) begin : g_node
		assign node[i] = (node[2*i+1] < node[2*i+2]) ? node[2*i+1] : node[2*i+2];
	end

	assign dmin = node[0];

endmodule

// ----- src/wmsum_row_min.sv -----
// Row window: shift line of the most recent pixels and their minimum over win_w.
// Depends on wmsum_pkg and wmsum_min_tree.
module wmsum_row_min #(
	parameter int MAX_WIN_W  = wmsum_pkg::MAX_WIN_W_DEF,
	parameter int PIXEL_BITS = wmsum_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                load,
	input  logic [PIXEL_BITS-1:0]               pixel,
	input  logic [wmsum_pkg::WINDOW_REG_W-1:0]  win_w,
	output logic [PIXEL_BITS-1:0]               hmin
);
	import wmsum_pkg::*;

	// Tap 0 holds the item now in stage 1, higher taps the older pixels
	logic [MAX_WIN_W-1:0][PIXEL_BITS-1:0] taps_q;
	logic [MAX_WIN_W-1:0]                 tap_en;

	always_ff @(posedge clk) begin
		if (load) begin
			taps_q[0] <= pixel;
			for (int k = 1; k < MAX_WIN_W; k++) begin
				taps_q[k] <= taps_q[k-1];
			end
		end
	end

	for (genvar k = 0; k < MAX_WIN_W; k++) begin : g_en
		assign tap_en[k] = (k < int'(win_w));
	end

	wmsum_min_tree #(
		.N (MAX_WIN_W),
		.W (PIXEL_BITS)
	) u_tree (
		.din  (taps_q),
		.en   (tap_en),
		.dmin (hmin)
	);

endmodule

// ----- src/wmsum_col_hist.sv -----
// Column history: one memory bank per row slot holding row minima by column,
// and the minimum over the last win_h rows. Depends on wmsum_pkg, wmsum_min_tree.
module wmsum_col_hist #(
	parameter int MAX_COLS   = wmsum_pkg::MAX_COLS_DEF,
	parameter int MAX_WIN_H  = wmsum_pkg::MAX_WIN_H_DEF,
	parameter int PIXEL_BITS = wmsum_pkg::PIXEL_BITS_DEF,
	parameter int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	parameter int SLOT_W     = (MAX_WIN_H > 1) ? $clog2(MAX_WIN_H) : 1
) (
	input  logic                                clk,
	input  wmsum_pkg::wmsum_hist_ctl_t          ctl,
	input  logic [COL_W-1:0]                    col,
	input  logic [SLOT_W-1:0]                   slot,
	input  logic [PIXEL_BITS-1:0]               hmin,
	input  logic [wmsum_pkg::WINDOW_REG_W-1:0]  win_h,
	output logic [PIXEL_BITS-1:0]               vmin
);
	import wmsum_pkg::*;

	logic [MAX_WIN_H-1:0][PIXEL_BITS-1:0] rd_s2;
	logic [MAX_WIN_H-1:0][PIXEL_BITS-1:0] lane;
	logic [MAX_WIN_H-1:0]                 lane_en;
	logic [PIXEL_BITS-1:0]                hmin_s2;
	logic [SLOT_W-1:0]                    slot_s2;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			hmin_s2 <= hmin;
			slot_s2 <= slot;
		end
	end

	for (genvar b = 0; b < MAX_WIN_H; b++) begin : g_bank
		logic [PIXEL_BITS-1:0] mem [MAX_COLS];
		logic [SLOT_W:0]       row_age;

		// The bank of the current row is written on the same edge as the
		// read; its old word is replaced by hmin_s2 below
		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				if (ctl.wr && (slot == SLOT_W'(b))) begin
					mem[col] <= hmin;
				end
				rd_s2[b] <= mem[col];
			end
		end

		// Rows back from the current row slot, modulo the bank count
		always_comb begin
			if ({1'b0, slot_s2} >= (SLOT_W+1)'(b)) begin
				row_age = {1'b0, slot_s2} - (SLOT_W+1)'(b);
			end else begin
				row_age = {1'b0, slot_s2} + (SLOT_W+1)'(MAX_WIN_H) - (SLOT_W+1)'(b);
			end
		end

		assign lane[b]    = (slot_s2 == SLOT_W'(b)) ? hmin_s2 : rd_s2[b];
		assign lane_en[b] = (int'(row_age) < int'(win_h));
	end

	wmsum_min_tree #(
		.N (MAX_WIN_H),
		.W (PIXEL_BITS)
	) u_tree (
		.din  (lane),
		.en   (lane_en),
		.dmin (vmin)
	);

endmodule
